/* sv/bthp_pkg.sv */
package bthp_pkg;

  // One payload byte as it arrives from the receiver.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Decoded readings, given once per frame on the last byte.
  typedef struct packed {
    logic               accepted;
    logic               encrypted;
    logic               temp_valid;
    logic               hum_valid;
    logic               batt_valid;
    logic               mv_valid;
    logic signed [15:0] temperature_centi;
    logic [15:0]        humidity_centi;
    logic [6:0]         battery_percent;
    logic [15:0]        millivolts;
  } out_word_t;

  // Store updates produced by one completed object.
  typedef struct packed {
    logic        temp_we;
    logic        hum_we;
    logic        batt_we;
    logic        mv_we;
    logic [15:0] temp;
    logic [15:0] hum;
    logic [6:0]  batt;
    logic [15:0] mv;
  } obj_update_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ID,
    PH_LEN,
    PH_VALUE,
    PH_SKIP
  } phase_t;

  localparam logic [2:0] HDR_VERSION = 3'd2;
  localparam logic [7:0] OBJ_COUNT   = 8'h61;
  localparam logic [7:0] SZ_VAR      = 8'hFF;
  localparam logic [7:0] SZ_NONE     = 8'h00;
  localparam logic [6:0] BATT_MAX    = 7'd100;

  localparam logic [6:0] ID_BATTERY   = 7'h01;
  localparam logic [6:0] ID_TEMP_C01  = 7'h02;
  localparam logic [6:0] ID_HUM_C01   = 7'h03;
  localparam logic [6:0] ID_VOLTAGE   = 7'h0C;
  localparam logic [6:0] ID_HUM_PCT   = 7'h2E;
  localparam logic [6:0] ID_TEMP_C1   = 7'h45;
  localparam logic [6:0] ID_TEMP_DEG  = 7'h57;

  // Object size in bytes for ids below OBJ_COUNT. Zero marks an unknown id and
  // SZ_VAR marks an object whose length byte follows the id.
  function automatic logic [7:0] obj_size(input logic [6:0] id);
    logic [7:0] sz;
    case (id) inside
      7'd0, 7'd1, 7'd9, 7'd15:              sz = 8'd1;
      7'd2, 7'd3, 7'd6, 7'd7, 7'd8:         sz = 8'd2;
      7'd4, 7'd5, 7'd10, 7'd11:             sz = 8'd3;
      7'd12, 7'd13, 7'd14:                  sz = 8'd2;
      [7'd16:7'd47]:                        sz = 8'd1;
      [7'd48:7'd57], 7'd59:                 sz = SZ_NONE;
      7'd58:                                sz = 8'd1;
      7'd60, 7'd61, 7'd63, 7'd64, 7'd65:    sz = 8'd2;
      7'd62:                                sz = 8'd4;
      7'd66, 7'd75:                         sz = 8'd3;
      7'd67, 7'd68, 7'd69, 7'd71, 7'd72:    sz = 8'd2;
      7'd73, 7'd74:                         sz = 8'd2;
      7'd70:                                sz = 8'd1;
      [7'd76:7'd80]:                        sz = 8'd4;
      7'd81, 7'd82, 7'd86:                  sz = 8'd2;
      7'd83, 7'd84:                         sz = SZ_VAR;
      7'd85, 7'd91, 7'd92:                  sz = 8'd4;
      7'd87, 7'd88, 7'd89, 7'd96:           sz = 8'd1;
      7'd90, 7'd93, 7'd94, 7'd95:           sz = 8'd2;
      default:                              sz = SZ_NONE;
    endcase
    return sz;
  endfunction

endpackage

/* sv/bthp_obj_apply.sv */
module bthp_obj_apply
  import bthp_pkg::*;
(
  input  logic [6:0]  id,
  input  logic [7:0]  lo,
  input  logic [7:0]  hi,
  output obj_update_t upd
);

  logic [15:0] w;
  logic [15:0] hi_sext;

  assign w       = {hi, lo};
  assign hi_sext = {{8{hi[7]}}, hi};

  // Scale temperature and humidity to hundredths; products keep low 16 bits.
  always_comb begin
    upd      = '0;
    upd.temp = '0;
    unique case (id)
      ID_BATTERY: begin
        upd.batt_we = 1'b1;
        upd.batt    = (hi > {1'b0, BATT_MAX}) ? BATT_MAX : hi[6:0];
      end
      ID_TEMP_C01: begin
        upd.temp_we = 1'b1;
        upd.temp    = w;
      end
      ID_TEMP_C1: begin
        upd.temp_we = 1'b1;
        upd.temp    = {w[12:0], 3'b000} + {w[14:0], 1'b0};
      end
      ID_TEMP_DEG: begin
        upd.temp_we = 1'b1;
        upd.temp    = hi_sext * 16'd100;
      end
      ID_HUM_C01: begin
        upd.hum_we = 1'b1;
        upd.hum    = w;
      end
      ID_HUM_PCT: begin
        upd.hum_we = 1'b1;
        upd.hum    = {8'd0, hi} * 16'd100;
      end
      ID_VOLTAGE: begin
        upd.mv_we = 1'b1;
        upd.mv    = w;
      end
      default: begin
        upd = '0;
      end
    endcase
  end

endmodule

/* sv/bthp_walker.sv */
module bthp_walker
  import bthp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_word_t  word,
  output out_word_t result
);

  phase_t      phase, phase_next;
  logic [6:0]  obj_id, obj_id_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic        first_pending, first_pending_next;
  logic [7:0]  first_val, first_val_next;
  logic [15:0] temp_store, temp_store_next;
  logic [15:0] hum_store, hum_store_next;
  logic [6:0]  batt_store, batt_store_next;
  logic [15:0] mv_store, mv_store_next;
  logic        f_acc, f_acc_next;
  logic        f_enc, f_enc_next;
  logic        f_temp, f_temp_next;
  logic        f_hum, f_hum_next;
  logic        f_batt, f_batt_next;
  logic        f_mv, f_mv_next;

  logic [7:0]  b;
  logic [7:0]  size;
  logic [7:0]  lo_byte;
  obj_update_t upd;

  assign b       = word.data_byte;
  assign size    = obj_size(b[6:0]);
  assign lo_byte = first_pending ? b : first_val;

  bthp_obj_apply u_apply (
    .id  (obj_id),
    .lo  (lo_byte),
    .hi  (b),
    .upd (upd)
  );

  always_comb begin
    phase_next         = phase;
    obj_id_next        = obj_id;
    bytes_left_next    = bytes_left;
    first_pending_next = first_pending;
    first_val_next     = first_val;
    temp_store_next    = temp_store;
    hum_store_next     = hum_store;
    batt_store_next    = batt_store;
    mv_store_next      = mv_store;
    f_acc_next         = f_acc;
    f_enc_next         = f_enc;
    f_temp_next        = f_temp;
    f_hum_next         = f_hum;
    f_batt_next        = f_batt;
    f_mv_next          = f_mv;
    if (step) begin
      unique case (phase)
        PH_HEADER: begin
          temp_store_next = '0;
          hum_store_next  = '0;
          batt_store_next = '0;
          mv_store_next   = '0;
          f_temp_next     = 1'b0;
          f_hum_next      = 1'b0;
          f_batt_next     = 1'b0;
          f_mv_next       = 1'b0;
          f_acc_next      = (b[7:5] == HDR_VERSION);
          f_enc_next      = (b[7:5] == HDR_VERSION) && b[0];
          if ((b[7:5] == HDR_VERSION) && !b[0]) begin
            phase_next = PH_ID;
          end else begin
            phase_next = PH_SKIP;
          end
        end
        PH_ID: begin
          if ((b >= OBJ_COUNT) || (size == SZ_NONE)) begin
            phase_next = PH_SKIP;
          end else begin
            obj_id_next        = b[6:0];
            first_pending_next = 1'b1;
            if (size == SZ_VAR) begin
              phase_next = PH_LEN;
            end else begin
              bytes_left_next = size;
              phase_next      = PH_VALUE;
            end
          end
        end
        PH_LEN: begin
          first_pending_next = 1'b1;
          if (b == 8'd0) begin
            phase_next = PH_ID;
          end else begin
            bytes_left_next = b;
            phase_next      = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (first_pending) begin
            first_val_next = b;
          end
          first_pending_next = 1'b0;
          bytes_left_next    = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase_next = PH_ID;
            if (upd.temp_we) begin
              temp_store_next = upd.temp;
              f_temp_next     = 1'b1;
            end
            if (upd.hum_we) begin
              hum_store_next = upd.hum;
              f_hum_next     = 1'b1;
            end
            if (upd.batt_we) begin
              batt_store_next = upd.batt;
              f_batt_next     = 1'b1;
            end
            if (upd.mv_we) begin
              mv_store_next = upd.mv;
              f_mv_next     = 1'b1;
            end
          end
        end
        default: begin
          phase_next = PH_SKIP;
        end
      endcase
      if (word.last_byte) begin
        phase_next = PH_HEADER;
      end
    end
  end

  // The result is taken from the updated stores, so the last byte counts.
  always_comb begin
    result.accepted          = f_acc_next;
    result.encrypted         = f_enc_next;
    result.temp_valid        = f_temp_next;
    result.hum_valid         = f_hum_next;
    result.batt_valid        = f_batt_next;
    result.mv_valid          = f_mv_next;
    result.temperature_centi = temp_store_next;
    result.humidity_centi    = hum_store_next;
    result.battery_percent   = batt_store_next;
    result.millivolts        = mv_store_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      first_pending <= 1'b0;
      f_acc         <= 1'b0;
      f_enc         <= 1'b0;
      f_temp        <= 1'b0;
      f_hum         <= 1'b0;
      f_batt        <= 1'b0;
      f_mv          <= 1'b0;
    end else begin
      phase         <= phase_next;
      first_pending <= first_pending_next;
      f_acc         <= f_acc_next;
      f_enc         <= f_enc_next;
      f_temp        <= f_temp_next;
      f_hum         <= f_hum_next;
      f_batt        <= f_batt_next;
      f_mv          <= f_mv_next;
    end
  end

  always_ff @(posedge clk) begin
    obj_id     <= obj_id_next;
    bytes_left <= bytes_left_next;
    first_val  <= first_val_next;
    temp_store <= temp_store_next;
    hum_store  <= hum_store_next;
    batt_store <= batt_store_next;
    mv_store   <= mv_store_next;
  end

endmodule

/* sv/bthome_v2_reading_parser_core.sv */
// An accepted word is captured in the input register and parsed from there; when it
// carries the last-byte mark, its result is held in the output register until taken.
// Throughput: one payload byte per cycle, except a last byte behind a stalled result.
// The output register lets the next frame's bytes keep flowing while a result waits.
// Reset (rst, synchronous, active high) empties both registers and returns the
// parser to expecting a header byte.
module bthome_v2_reading_parser_core
  import bthp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_word_t  byte_word,
  output logic      result_valid,
  input  logic      result_stall,
  output out_word_t result_word
);

  // Input register: holds one byte word until the parser consumes it.
  in_word_t  in_q;
  logic      in_full;

  // Output register: holds one finished result until downstream takes it.
  out_word_t res_q;
  logic      out_full;

  logic      proc_go;
  logic      byte_take;
  out_word_t res_next;

  // A byte without the last mark never needs the output register, so only a
  // last byte can be held back, and only while an old result is still stalled.
  assign proc_go    = in_full && (!in_q.last_byte || !out_full || !result_stall);
  assign byte_stall = in_full && !proc_go;
  assign byte_take  = byte_valid && !byte_stall;

  bthp_walker u_walker (
    .clk    (clk),
    .rst    (rst),
    .step   (proc_go),
    .word   (in_q),
    .result (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_take) begin
      in_full <= 1'b1;
    end else if (proc_go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      in_q <= byte_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (proc_go && in_q.last_byte) begin
      out_full <= 1'b1;
    end else if (!result_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && in_q.last_byte) begin
      res_q <= res_next;
    end
  end

  assign result_valid = out_full;
  assign result_word  = res_q;

  // A byte that is not the last one is always consumed in the cycle it is held.
  a_mid_byte_flows: assert property (@(posedge clk) disable iff (rst)
    in_full && !in_q.last_byte |-> proc_go)
    else $error("mid-frame byte held in input register");

  // Parsing a last byte always leaves a result in the output register.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    proc_go && in_q.last_byte |=> result_valid)
    else $error("last byte parsed but no result presented");

  // A rejected header leaves every other flag clear.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_word.accepted |->
      !result_word.encrypted && !result_word.temp_valid && !result_word.hum_valid &&
      !result_word.batt_valid && !result_word.mv_valid)
    else $error("rejected frame reports readings");

  // An encrypted frame carries no readings.
  a_encrypted_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.encrypted |->
      !result_word.temp_valid && !result_word.hum_valid &&
      !result_word.batt_valid && !result_word.mv_valid)
    else $error("encrypted frame reports readings");

  // Battery level is saturated.
  a_batt_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_word.battery_percent <= BATT_MAX)
    else $error("battery level above saturation limit");

endmodule

/* tb/bthome_v2_reading_parser_core_tb.sv */
module bthome_v2_reading_parser_core_tb;
  import bthp_pkg::*;

  // The run is stopped when this many cycles pass with no word moving on either side.
  // The longest legal quiet stretch comes from the receiver hold-off below.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DIRECTED_ROWS = 26;
  localparam int WORDS_PER_PHASE = 420;
  localparam int MAX_REPORTS = 10;

  // Object sizes for ids 0x00 to 0x60, one hex digit per id with id 0x00 leftmost.
  // Zero marks an id the decoder does not know; F marks a length byte after the id.
  localparam logic [4*97-1:0] SIZE_DIGITS = {
    64'h1122332221332221, 64'h1111111111111111, 64'h1111111111111111,
    64'h0000000000102242, 64'h2232221222234444, 64'h422FF42111244222, 4'h1
  };
  localparam logic [3:0] LEN_FOLLOWS = 4'hF;
  localparam logic [3:0] NO_SUCH_ID = 4'h0;

  // One stimulus word, with a hand-written expected reading where typed is set.
  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t exp;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_word_t  byte_word = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_word_t result_word;

  bthome_v2_reading_parser_core u_dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_word(byte_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_word(result_word)
  );

  always #5 clk = ~clk;

  // Words waiting to be offered, readings waiting to come out, and run bookkeeping.
  stim_t     send_q[$];
  out_word_t reading_q[$];
  stim_t     cur_word;
  int        words_left = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  bit        hold_req = 1'b0;
  int        hold_cnt = 0;
  int        quiet_cycles = 0;
  int        mismatches = 0;
  int        stray_results = 0;
  int        words_sent = 0;
  int        frames_seen = 0;
  int        n_rejected = 0;
  int        n_encrypted = 0;
  int        n_temp = 0;
  int        n_hum = 0;
  int        n_batt = 0;
  int        n_mv = 0;

  // Decoder state as this testbench tracks it, matching the block after reset.
  phase_t      dec_phase = PH_HEADER;
  logic [6:0]  dec_id = '0;
  logic [8:0]  dec_left = '0;
  logic [7:0]  dec_index = '0;
  logic [7:0]  dec_first = '0;
  logic [15:0] dec_temp = '0;
  logic [15:0] dec_hum = '0;
  logic [6:0]  dec_batt = '0;
  logic [15:0] dec_mv = '0;
  logic        got_acc = 1'b0;
  logic        got_enc = 1'b0;
  logic        got_temp = 1'b0;
  logic        got_hum = 1'b0;
  logic        got_batt = 1'b0;
  logic        got_mv = 1'b0;

  function automatic logic [3:0] object_bytes(input logic [7:0] id);
    if (id >= OBJ_COUNT) return NO_SUCH_ID;
    return SIZE_DIGITS[4*(96 - id) +: 4];
  endfunction

  // Flags run accepted, encrypted, then the four reading valids.
  function automatic out_word_t reading(input logic [5:0] flags, input logic [15:0] t,
                                        input logic [15:0] h, input logic [6:0] bt,
                                        input logic [15:0] mv);
    return {flags, t, h, bt, mv};
  endfunction

  // A completed object updates the reading it carries. Only the first and the last
  // value byte matter, since every decoded kind is one or two bytes long.
  task automatic apply_reading(input logic [7:0] lo, input logic [7:0] hi);
    logic [15:0] w;
    logic signed [15:0] deg;
    w = {hi, lo};
    deg = $signed({{8{hi[7]}}, hi}) * 16'sd100;
    case (dec_id)
      ID_BATTERY: begin
        dec_batt = (hi > {1'b0, BATT_MAX}) ? BATT_MAX : hi[6:0];
        got_batt = 1'b1;
      end
      ID_TEMP_C01: begin
        dec_temp = w;
        got_temp = 1'b1;
      end
      ID_TEMP_C1: begin
        dec_temp = w * 16'd10;
        got_temp = 1'b1;
      end
      ID_TEMP_DEG: begin
        dec_temp = deg;
        got_temp = 1'b1;
      end
      ID_HUM_C01: begin
        dec_hum = w;
        got_hum = 1'b1;
      end
      ID_HUM_PCT: begin
        dec_hum = {8'd0, hi} * 16'd100;
        got_hum = 1'b1;
      end
      ID_VOLTAGE: begin
        dec_mv = w;
        got_mv = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Advances the tracked decoder by one word; done is set when the word closes a frame.
  task automatic decode_byte(input in_word_t w, output bit done, output out_word_t rd);
    logic [7:0] b;
    b = w.data_byte;
    done = 1'b0;
    rd = '0;
    case (dec_phase)
      PH_HEADER: begin
        {dec_temp, dec_hum, dec_batt, dec_mv} = '0;
        {got_acc, got_enc, got_temp, got_hum, got_batt, got_mv} = '0;
        if (b[7:5] != HDR_VERSION) begin
          dec_phase = PH_SKIP;
        end else if (b[0]) begin
          got_acc = 1'b1;
          got_enc = 1'b1;
          dec_phase = PH_SKIP;
        end else begin
          got_acc = 1'b1;
          dec_phase = PH_ID;
        end
      end
      PH_ID: begin
        if (object_bytes(b) == NO_SUCH_ID) begin
          dec_phase = PH_SKIP;
        end else begin
          dec_id = b[6:0];
          dec_index = '0;
          if (object_bytes(b) == LEN_FOLLOWS) begin
            dec_phase = PH_LEN;
          end else begin
            dec_left = {5'd0, object_bytes(b)};
            dec_phase = PH_VALUE;
          end
        end
      end
      PH_LEN: begin
        dec_index = '0;
        if (b == 8'd0) begin
          dec_phase = PH_ID;
        end else begin
          dec_left = {1'b0, b};
          dec_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (dec_index == 8'd0) dec_first = b;
        dec_index = dec_index + 8'd1;
        dec_left = dec_left - 9'd1;
        if (dec_left == 9'd0) begin
          apply_reading(dec_first, b);
          dec_phase = PH_ID;
        end
      end
      default: dec_phase = PH_SKIP;
    endcase
    if (w.last_byte) begin
      done = 1'b1;
      rd = reading({got_acc, got_enc, got_temp, got_hum, got_batt, got_mv},
                   dec_temp, dec_hum, dec_batt, dec_mv);
      dec_phase = PH_HEADER;
    end
  endtask

  // The directed table. Rows whose reading is obvious carry it typed in; the rest
  // are checked against the tracked decoder like the random words are.
  function automatic stim_t directed_row(input int i);
    stim_t r;
    case (i)
      // Header alone, then a header with the wrong version, then an encrypted header.
      0:  r = {8'h40, 1'b1, 1'b1, reading(6'b100000, 16'h0, 16'h0, 7'd0, 16'h0)};
      1:  r = {8'hE0, 1'b1, 1'b1, reading(6'b000000, 16'h0, 16'h0, 7'd0, 16'h0)};
      2:  r = {8'h41, 1'b1, 1'b1, reading(6'b110000, 16'h0, 16'h0, 7'd0, 16'h0)};
      // Battery above 100 saturates, temperature at its most negative, voltage at max.
      3:  r = {8'h40, 1'b0, 1'b0, out_word_t'('0)};
      4:  r = {8'h01, 1'b0, 1'b0, out_word_t'('0)};
      5:  r = {8'hFF, 1'b0, 1'b0, out_word_t'('0)};
      6:  r = {8'h02, 1'b0, 1'b0, out_word_t'('0)};
      7:  r = {8'h00, 1'b0, 1'b0, out_word_t'('0)};
      8:  r = {8'h80, 1'b0, 1'b0, out_word_t'('0)};
      9:  r = {8'h0C, 1'b0, 1'b0, out_word_t'('0)};
      10: r = {8'hFF, 1'b0, 1'b0, out_word_t'('0)};
      11: r = {8'hFF, 1'b1, 1'b1,
               reading(6'b101011, 16'h8000, 16'h0, 7'd100, 16'hFFFF)};
      // Tenths that wrap, whole degrees that win over them, and a truncated humidity.
      12: r = {8'h40, 1'b0, 1'b0, out_word_t'('0)};
      13: r = {8'h45, 1'b0, 1'b0, out_word_t'('0)};
      14: r = {8'hFF, 1'b0, 1'b0, out_word_t'('0)};
      15: r = {8'h7F, 1'b0, 1'b0, out_word_t'('0)};
      16: r = {8'h57, 1'b0, 1'b0, out_word_t'('0)};
      17: r = {8'h80, 1'b0, 1'b0, out_word_t'('0)};
      18: r = {8'h03, 1'b0, 1'b0, out_word_t'('0)};
      19: r = {8'hFF, 1'b1, 1'b0, out_word_t'('0)};
      // Whole-percent humidity, an empty variable-length object, then an id past the table.
      20: r = {8'h40, 1'b0, 1'b0, out_word_t'('0)};
      21: r = {8'h2E, 1'b0, 1'b0, out_word_t'('0)};
      22: r = {8'hFF, 1'b0, 1'b0, out_word_t'('0)};
      23: r = {8'h54, 1'b0, 1'b0, out_word_t'('0)};
      24: r = {8'h00, 1'b0, 1'b0, out_word_t'('0)};
      default: r = {8'hE5, 1'b1, 1'b0, out_word_t'('0)};
    endcase
    return r;
  endfunction

  task automatic queue_word(input stim_t s);
    send_q.push_back(s);
    words_left++;
    words_sent++;
  endtask

  // Value bytes lean toward the extremes so that saturation and wrapping show up often.
  function automatic logic [7:0] value_byte();
    int p;
    p = $urandom_range(99);
    if (p < 10) return 8'h00;
    if (p < 20) return 8'hFF;
    if (p < 25) return 8'h80;
    if (p < 30) return 8'h7F;
    return 8'($urandom_range(255));
  endfunction

  // Builds one frame. Most frames are well formed with random content; a few are
  // noise, rejected or encrypted headers, unknown ids, or cut short.
  task automatic queue_frame(input int max_objects);
    logic [7:0] bytes_q[$];
    logic [7:0] hdr;
    logic [7:0] id;
    logic [7:0] len;
    logic [3:0] sz;
    int p, n_obj, cut, v;
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(1, 8)) bytes_q.push_back(8'($urandom_range(255)));
    end else begin
      hdr = 8'($urandom_range(255));
      hdr[7:5] = HDR_VERSION;
      hdr[0] = 1'b0;
      p = $urandom_range(99);
      if (p < 8) begin
        hdr[0] = 1'b1;
      end else if (p < 14) begin
        v = $urandom_range(6);
        if (v >= HDR_VERSION) v++;
        hdr[7:5] = 3'(v);
      end
      bytes_q.push_back(hdr);
      n_obj = $urandom_range(0, max_objects);
      repeat (n_obj) begin
        p = $urandom_range(99);
        if (p < 55) begin
          case ($urandom_range(6))
            0: id = {1'b0, ID_BATTERY};
            1: id = {1'b0, ID_TEMP_C01};
            2: id = {1'b0, ID_HUM_C01};
            3: id = {1'b0, ID_VOLTAGE};
            4: id = {1'b0, ID_HUM_PCT};
            5: id = {1'b0, ID_TEMP_C1};
            default: id = {1'b0, ID_TEMP_DEG};
          endcase
        end else if (p < 80) begin
          id = 8'($urandom_range(OBJ_COUNT - 1));
        end else if (p < 93) begin
          id = $urandom_range(1) ? 8'h53 : 8'h54;
        end else begin
          id = 8'($urandom_range(OBJ_COUNT, 255));
        end
        bytes_q.push_back(id);
        sz = object_bytes(id);
        if (sz == LEN_FOLLOWS) begin
          len = ($urandom_range(39) == 0) ? 8'd255 : 8'($urandom_range(5));
          bytes_q.push_back(len);
          repeat (len) bytes_q.push_back(value_byte());
        end else begin
          // After an unknown id the decoder only skips, so any bytes will do here.
          repeat ((sz == NO_SUCH_ID) ? 2 : sz) bytes_q.push_back(value_byte());
        end
      end
      if ($urandom_range(9) == 0 && bytes_q.size() > 1) begin
        cut = $urandom_range(1, bytes_q.size() - 1);
        repeat (cut) void'(bytes_q.pop_back());
      end
    end
    foreach (bytes_q[i])
      queue_word({bytes_q[i], i == bytes_q.size() - 1, 1'b0, out_word_t'('0)});
  endtask

  // Sender. A word is taken at an edge where valid is high and stall is low; only
  // then, or while nothing is offered, may the next word or a gap be chosen.
  always @(posedge clk) begin
    bit done;
    out_word_t rd;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        decode_byte(cur_word.w, done, rd);
        if (done) reading_q.push_back(cur_word.typed ? cur_word.exp : rd);
        words_left--;
      end
      if (!byte_valid || !byte_stall) begin
        if (send_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_word = send_q.pop_front();
          byte_word <= cur_word.w;
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. A requested hold-off keeps stall high for a counted stretch so that the
  // output register stays full and the block has to stall its input.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic string show(input out_word_t w);
    return $sformatf("acc=%0b enc=%0b valids=%0b%0b%0b%0b temp=%0d hum=%0d batt=%0d mv=%0d",
                     w.accepted, w.encrypted, w.temp_valid, w.hum_valid, w.batt_valid,
                     w.mv_valid, $signed(w.temperature_centi), w.humidity_centi,
                     w.battery_percent, w.millivolts);
  endfunction

  // Compares one delivered reading with the oldest one still owed.
  task automatic check_reading(input out_word_t got);
    out_word_t want;
    bit bad;
    if (reading_q.size() == 0) begin
      stray_results++;
      if (mismatches + stray_results <= MAX_REPORTS)
        $display("ERROR: reading with none owed: %s", show(got));
    end else begin
      want = reading_q.pop_front();
      frames_seen++;
      if (!want.accepted) n_rejected++;
      if (want.encrypted) n_encrypted++;
      n_temp += want.temp_valid;
      n_hum += want.hum_valid;
      n_batt += want.batt_valid;
      n_mv += want.mv_valid;
      bad = got.accepted !== want.accepted || got.encrypted !== want.encrypted ||
            got.temp_valid !== want.temp_valid || got.hum_valid !== want.hum_valid ||
            got.batt_valid !== want.batt_valid || got.mv_valid !== want.mv_valid ||
            got.temperature_centi !== want.temperature_centi ||
            got.humidity_centi !== want.humidity_centi ||
            got.battery_percent !== want.battery_percent ||
            got.millivolts !== want.millivolts;
      if (bad) begin
        mismatches++;
        if (mismatches + stray_results <= MAX_REPORTS) begin
          $display("ERROR: frame %0d reading differs", frames_seen);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_reading(result_word);
  end

  // Watchdog: ends a run that has stopped moving words in both directions.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles", QUIET_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Waits until every queued word has been taken and every owed reading has arrived.
  task automatic drain();
    do @(posedge clk); while (words_left != 0 || reading_q.size() != 0);
  endtask

  initial begin
    int phase_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table, sent back to back with the receiver always ready.
    for (int i = 0; i < DIRECTED_ROWS; i++) queue_word(directed_row(i));
    drain();

    // Random frames under four idling mixes: none, sender gaps, receiver stalls, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < WORDS_PER_PHASE) queue_frame(6);
      drain();
    end

    // Back pressure: the receiver holds off while short frames keep arriving.
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    repeat (60) queue_frame(1);
    drain();

    // The block answers through its input and output registers, so the quiet cycles below expose stray readings.
    repeat (6) @(posedge clk);

    $display("Covered %0d words in %0d frames: %0d rejected, %0d encrypted.",
             words_sent, frames_seen, n_rejected, n_encrypted);
    $display("Readings decoded: temperature %0d, humidity %0d, battery %0d, voltage %0d.",
             n_temp, n_hum, n_batt, n_mv);
    if (mismatches == 0 && stray_results == 0 && reading_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* bthome_v2_reading_parser_core.f */
sv/bthp_pkg.sv
sv/bthp_obj_apply.sv
sv/bthp_walker.sv
sv/bthome_v2_reading_parser_core.sv
tb/bthome_v2_reading_parser_core_tb.sv
